// ===== design/sxu_pkg.sv =====
// Shared constants and types of the system-exclusive unpacker.
package sxu_pkg;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 14;
   localparam int SUM_W       = 16;
   localparam int GRP_DEPTH   = 7;
   localparam int GRP_W       = 3;
   localparam int POS_PKT     = 5;
   localparam int POS_LEN_HI  = 6;
   localparam int POS_LEN_LO  = 7;
   localparam int BODY_START  = 11;
   localparam int MIN_MSG_LEN = 11;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;

   typedef enum logic [1:0] {
      VERDICT_OK      = 2'd0,
      VERDICT_BAD_SUM = 2'd1,
      VERDICT_SHORT   = 2'd2
   } verdict_type;

   typedef struct packed {
      logic                             has_data;
      logic [GRP_W-1:0]                 grp_size;
      logic [GRP_DEPTH-1:0][BYTE_W-1:0] grp_bytes;
      logic [BYTE_W-1:0]                top_bits;
      logic [LEN_W-1:0]                 base_pos;
      logic                             has_status;
      verdict_type                      verdict;
      logic [BYTE_W-1:0]                packet_number;
      logic [LEN_W-1:0]                 decoded_length;
   } job_type;

endpackage

// ===== design/sxu_if.sv =====
// Request and response channel interfaces of the system-exclusive unpacker.
interface sxu_req_if;
   logic                      valid;
   logic                      ready;
   logic [sxu_pkg::BYTE_W-1:0] msg_byte;
   logic                      final_byte;

   modport source (output valid, output msg_byte, output final_byte, input ready);
   modport sink   (input valid, input msg_byte, input final_byte, output ready);
endinterface

interface sxu_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       is_status;
   logic [sxu_pkg::BYTE_W-1:0] data_value;
   logic [sxu_pkg::LEN_W-1:0]  data_position;
   logic [1:0]                 verdict;
   logic [sxu_pkg::BYTE_W-1:0] packet_number;
   logic [sxu_pkg::LEN_W-1:0]  decoded_length;
   logic                       last_result;

   modport source (output valid, output is_status, output data_value,
                   output data_position, output verdict, output packet_number,
                   output decoded_length, output last_result, input ready);
   modport sink   (input valid, input is_status, input data_value,
                   input data_position, input verdict, input packet_number,
                   input decoded_length, input last_result, output ready);
endinterface

// ===== design/sxu_front.sv =====
// Front end: header capture, body delay, checksum, group collection and job issue.
module sxu_front #(
   parameter int MAX_MSG_LEN = 255
) (
   input  logic             clock,
   input  logic             reset,
   sxu_req_if.sink          req,
   input  logic             q_full,
   output logic             push,
   output sxu_pkg::job_type job
);
   import sxu_pkg::*;

   localparam int POS_W = $clog2(MAX_MSG_LEN + 1);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_MSG_LEN);

   logic [POS_W-1:0]                 pos_ff, pos_in;
   logic [2:0][BYTE_W-1:0]           dly_ff, dly_in;
   logic [SUM_W-1:0]                 sum_ff, sum_in;
   logic [LEN_W-1:0]                 len_ff, len_in;
   logic [BYTE_W-1:0]                pkt_ff, pkt_in;
   logic [LEN_W-1:0]                 dec_ff, dec_in;
   logic [GRP_DEPTH-1:0][BYTE_W-1:0] grp_ff, grp_in;
   logic [GRP_W-1:0]                 fill_ff, fill_in;

   logic              accept;
   logic              close;
   logic [BYTE_W-1:0] leaving;
   logic [LEN_W-1:0]  remain;
   logic [GRP_W-1:0]  grp_size;
   verdict_type       verdict;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign leaving   = dly_ff[2];

   always_comb begin
      pos_in   = (pos_ff < POS_MAX) ? pos_ff + POS_W'(1) : pos_ff;
      pkt_in   = pkt_ff;
      len_in   = len_ff;
      sum_in   = sum_ff;
      dec_in   = dec_ff;
      grp_in   = grp_ff;
      fill_in  = fill_ff;
      close    = 1'b0;
      remain   = '0;
      grp_size = '0;

      if (pos_ff == POS_W'(POS_PKT)) begin
         pkt_in = req.msg_byte;
      end else if (pos_ff == POS_W'(POS_LEN_HI)) begin
         len_in = {req.msg_byte[6:0], 7'b0};
      end else if (pos_ff == POS_W'(POS_LEN_LO)) begin
         len_in = len_ff | {6'b0, req.msg_byte};
      end

      dly_in[2] = dly_ff[1];
      dly_in[1] = dly_ff[0];
      dly_in[0] = req.msg_byte;

      if (pos_ff >= POS_W'(BODY_START)) begin
         sum_in = {sum_ff[SUM_W-2:0], sum_ff[SUM_W-1]} + {8'b0, leaving};
         if (dec_ff < len_in) begin
            remain   = len_in - dec_ff;
            grp_size = (remain < LEN_W'(GRP_DEPTH)) ? remain[GRP_W-1:0]
                                                     : GRP_W'(GRP_DEPTH);
            if (fill_ff < grp_size) begin
               grp_in[fill_ff] = leaving;
               fill_in         = fill_ff + GRP_W'(1);
            end else begin
               close   = 1'b1;
               dec_in  = dec_ff + LEN_W'(grp_size);
               fill_in = '0;
            end
         end
      end

      if (pos_ff < POS_W'(MIN_MSG_LEN - 1)) begin
         verdict = VERDICT_SHORT;
      end else if ({1'b0, sum_in[14:8]} != dly_in[2] || {1'b0, sum_in[6:0]} != dly_in[1]) begin
         verdict = VERDICT_BAD_SUM;
      end else if (dec_in < len_in) begin
         verdict = VERDICT_SHORT;
      end else begin
         verdict = VERDICT_OK;
      end
   end

   always_comb begin
      job.has_data       = close;
      job.grp_size       = grp_size;
      job.grp_bytes      = grp_ff;
      job.top_bits       = leaving;
      job.base_pos       = dec_ff;
      job.has_status     = req.final_byte;
      job.verdict        = verdict;
      job.packet_number  = pkt_in;
      job.decoded_length = len_in;
      push               = accept && (close || req.final_byte);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         dly_ff  <= '0;
         sum_ff  <= '0;
         len_ff  <= '0;
         pkt_ff  <= '0;
         dec_ff  <= '0;
         fill_ff <= '0;
      end else if (accept) begin
         if (req.final_byte) begin
            pos_ff  <= '0;
            dly_ff  <= '0;
            sum_ff  <= '0;
            len_ff  <= '0;
            pkt_ff  <= '0;
            dec_ff  <= '0;
            fill_ff <= '0;
         end else begin
            pos_ff  <= pos_in;
            dly_ff  <= dly_in;
            sum_ff  <= sum_in;
            len_ff  <= len_in;
            pkt_ff  <= pkt_in;
            dec_ff  <= dec_in;
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         grp_ff <= grp_in;
      end
   end

endmodule

// ===== design/sxu_queue.sv =====
// Short job queue between the front end and the back end.
module sxu_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sxu_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output sxu_pkg::job_type head
);
   import sxu_pkg::*;

   job_type                slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   assign full  = (count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_PTR_W + 1)'(push) - (QUEUE_PTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== design/sxu_back.sv =====
// Back end: walks each job and emits decoded bytes and the status response.
module sxu_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  sxu_pkg::job_type head,
   output logic             pop,
   sxu_rsp_if.source        rsp
);
   import sxu_pkg::*;

   logic [GRP_W-1:0]  step_ff, step_in;
   logic              valid_ff;
   logic              is_status_ff, is_status_in;
   logic [BYTE_W-1:0] value_ff, value_in;
   logic [LEN_W-1:0]  position_ff, position_in;
   logic [1:0]        verdict_ff, verdict_in;
   logic [BYTE_W-1:0] pkt_ff;
   logic [LEN_W-1:0]  len_ff;
   logic              last_ff, last_in;

   logic             load;
   logic             take;
   logic             is_data;
   logic [GRP_W-1:0] shift;
   logic             top;

   assign load = !valid_ff || rsp.ready;
   assign take = load && !q_empty;

   always_comb begin
      is_data = head.has_data && (step_ff < head.grp_size);
      shift   = head.grp_size - GRP_W'(1) - step_ff;
      top     = head.top_bits[shift];
      if (is_data) begin
         is_status_in = 1'b0;
         value_in     = head.grp_bytes[step_ff] | {top, 7'b0};
         position_in  = head.base_pos + LEN_W'(step_ff);
         verdict_in   = VERDICT_OK;
         last_in      = (step_ff == head.grp_size - GRP_W'(1)) && !head.has_status;
      end else begin
         is_status_in = 1'b1;
         value_in     = '0;
         position_in  = '0;
         verdict_in   = head.verdict;
         last_in      = 1'b1;
      end
      pop     = take && last_in;
      step_in = step_ff;
      if (pop) begin
         step_in = '0;
      end else if (take) begin
         step_in = step_ff + GRP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (load) begin
            valid_ff <= !q_empty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         is_status_ff <= is_status_in;
         value_ff     <= value_in;
         position_ff  <= position_in;
         verdict_ff   <= verdict_in;
         pkt_ff       <= head.packet_number;
         len_ff       <= head.decoded_length;
         last_ff      <= last_in;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.is_status      = is_status_ff;
   assign rsp.data_value     = value_ff;
   assign rsp.data_position  = position_ff;
   assign rsp.verdict        = verdict_ff;
   assign rsp.packet_number  = pkt_ff;
   assign rsp.decoded_length = len_ff;
   assign rsp.last_result    = last_ff;

endmodule

// ===== design/sysex_7bit_unpack_checksum.sv =====
// Top level of the system-exclusive 7-bit to 8-bit unpacker with checksum check.
// Each request carries one message byte, the last one marked by final_byte.
// The front end takes a request every cycle while its two-entry job queue
// has room; a request that closes a body group, or ends the message, queues
// one job. The back end turns each job into responses at one per cycle while
// rsp.ready allows, through a single output register: up to seven decoded
// bytes, then the status response when the message ends. A group-closing
// request therefore yields up to eight responses, and that response port sets
// the sustained rate; plain body and header bytes yield no response. Decoded
// bytes go out as each group closes, before the checksum verdict is known.
// No clearing pass is needed after reset.
module sysex_7bit_unpack_checksum #(
   parameter int MAX_MSG_LEN = 255
) (
   input  logic      clock,
   input  logic      reset,
   sxu_req_if.sink   req,
   sxu_rsp_if.source rsp
);
   import sxu_pkg::*;

   logic    push;
   logic    pop;
   logic    q_full;
   logic    q_empty;
   job_type push_job;
   job_type head_job;

   sxu_front #(
      .MAX_MSG_LEN (MAX_MSG_LEN)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .q_full (q_full),
      .push   (push),
      .job    (push_job)
   );

   sxu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (pop),
      .empty    (q_empty),
      .head     (head_job)
   );

   sxu_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .head    (head_job),
      .pop     (pop),
      .rsp     (rsp)
   );

endmodule
